// ----- design/fixed_frame_slave_responder_core_assert.svh -----
// assertion macros shared by the responder rtl
`ifndef FIXED_FRAME_SLAVE_RESPONDER_CORE_ASSERT_SVH
`define FIXED_FRAME_SLAVE_RESPONDER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FSFR_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define FSFR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("%m: assertion failed");

`endif

// ----- design/fsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// fsfr_pkg
// Types and constants of the fixed frame slave responder.
// ----------------------------------------------------------------------------
package fsfr_pkg;

   localparam int FRAME_BYTES = 20;
   localparam int POS_W       = 5;
   localparam int OWN_W       = 4;

   localparam logic [POS_W-1:0] POS_ADDR    = 5'd0;
   localparam logic [POS_W-1:0] POS_CMD     = 5'd1;
   localparam logic [POS_W-1:0] POS_DATA0   = 5'd2;
   localparam logic [POS_W-1:0] POS_DATA1   = 5'd3;
   localparam logic [POS_W-1:0] POS_CRC_LO  = 5'd18;
   localparam logic [POS_W-1:0] POS_CRC_HI  = 5'd19;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] CMD_ADDR_WRITE = 8'hFF;
   localparam logic [7:0] CMD_STATUS     = 8'h01;
   localparam logic [7:0] CMD_IDENT      = 8'h07;

   localparam logic [7:0] MASTER_ADDR      = 8'h00;
   localparam logic [7:0] STATUS_DATA1     = 8'h64;
   localparam logic [7:0] IDENT_DATA0      = 8'hFE;
   localparam logic [7:0] IDENT_DATA1      = 8'h0C;
   localparam logic [7:0] ZERO_BYTE        = 8'h00;

   localparam logic       KIND_REPLY  = 1'b0;
   localparam logic       KIND_NOTICE = 1'b1;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_CHECK,
      ST_REPLY,
      ST_NOTICE
   } state_type;

   typedef struct packed {
      logic init;
      logic step;
   } crc_ctrl_type;

endpackage

// ----- design/fsfr_crc_unit.sv -----
// ----------------------------------------------------------------------------
// fsfr_crc_unit
// Shared CRC16-MODBUS accumulator, one byte per step.
// ----------------------------------------------------------------------------
module fsfr_crc_unit (
   input  logic                  clock,
   input  fsfr_pkg::crc_ctrl_type ctrl,
   input  logic [7:0]            data_byte,
   output logic [15:0]           crc_value
);
   import fsfr_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] base;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = crc ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   always_comb begin
      base   = ctrl.init ? CRC_INIT : crc_ff;
      crc_in = ctrl.step ? crc_byte(base, data_byte) : crc_ff;
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc_value = crc_ff;

endmodule

// ----- design/fixed_frame_slave_responder_core.sv -----
// a request byte is taken per cycle while a frame is collected (req_stall low)
// after the twentieth byte: a check state, then 20 reply bytes one per cycle
// (or one notice), gated by rsp_stall; the first result passes the check state,
// the reply or notice state and the output register; req_stall stays high in
// the check state and in the reply or notice state, also for a dropped frame
// reset: collection restarts at position 0, own address 1, broadcast address 0
// ----------------------------------------------------------------------------
// fixed_frame_slave_responder_core
// Collects 20-byte frames, checks CRC16-MODBUS and answers addressed frames.
// ----------------------------------------------------------------------------
`include "fixed_frame_slave_responder_core_assert.svh"

module fixed_frame_slave_responder_core #(
   parameter int ADDR_MAX = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);
   import fsfr_pkg::*;

   localparam logic [7:0] ADDR_MAX_BYTE = 8'(ADDR_MAX);

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   cnt_ff, cnt_in;
   logic [OWN_W-1:0]   own_ff, own_in;
   logic [7:0]         bcast_ff, bcast_in;
   logic [7:0]         addr_ff, cmd_ff, data0_ff, crc_lo_ff, crc_hi_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_accept;
   logic               slot_free;
   logic               crc_ok, for_me, set_addr, addr_ok;
   logic               load_out;
   logic [7:0]         reply_byte;
   logic [7:0]         crc_data;
   logic [15:0]        crc_value;
   crc_ctrl_type       crc_ctrl;

   fsfr_crc_unit u_crc (
      .clock     (clock),
      .ctrl      (crc_ctrl),
      .data_byte (crc_data),
      .crc_value (crc_value)
   );

   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign crc_ok   = (crc_value == {crc_hi_ff, crc_lo_ff});
   assign for_me   = (addr_ff == bcast_ff) || (addr_ff == {4'h0, own_ff});
   assign set_addr = (cmd_ff == CMD_ADDR_WRITE);
   assign addr_ok  = (data0_ff != ZERO_BYTE) && (data0_ff <= ADDR_MAX_BYTE);

   // reply byte for the current output position
   always_comb begin
      case (cnt_ff)
         POS_ADDR:   reply_byte = MASTER_ADDR;
         POS_CMD:    reply_byte = cmd_ff;
         POS_DATA0:  reply_byte = (cmd_ff == CMD_IDENT) ? IDENT_DATA0 : ZERO_BYTE;
         POS_DATA1:  reply_byte = (cmd_ff == CMD_IDENT)  ? IDENT_DATA1 :
                                  (cmd_ff == CMD_STATUS) ? STATUS_DATA1 : ZERO_BYTE;
         POS_CRC_LO: reply_byte = crc_value[7:0];
         POS_CRC_HI: reply_byte = crc_value[15:8];
         default:    reply_byte = ZERO_BYTE;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_accept && pos_ff == POS_CRC_HI) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!crc_ok || !for_me) state_in = ST_COLLECT;
            else if (set_addr)      state_in = addr_ok ? ST_NOTICE : ST_COLLECT;
            else                    state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free && cnt_ff == POS_CRC_HI) state_in = ST_COLLECT;
         end
         ST_NOTICE: begin
            if (slot_free) state_in = ST_COLLECT;
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall     = 1'b1;
      load_out      = 1'b0;
      crc_ctrl.init = 1'b0;
      crc_ctrl.step = 1'b0;
      crc_data      = req_rx_byte;
      rsp_kind_in   = KIND_REPLY;
      rsp_byte_in   = reply_byte;
      rsp_last_in   = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_stall     = 1'b0;
            crc_ctrl.init = (pos_ff == POS_ADDR);
            crc_ctrl.step = req_accept && (pos_ff < POS_CRC_LO);
         end
         ST_CHECK: begin
         end
         ST_REPLY: begin
            load_out      = slot_free;
            crc_data      = reply_byte;
            crc_ctrl.init = (cnt_ff == POS_ADDR);
            crc_ctrl.step = slot_free && (cnt_ff < POS_CRC_LO);
            rsp_last_in   = (cnt_ff == POS_CRC_HI);
         end
         ST_NOTICE: begin
            load_out    = slot_free;
            rsp_kind_in = KIND_NOTICE;
            rsp_byte_in = {4'h0, own_ff};
            rsp_last_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      if (req_accept) pos_in = (pos_ff == POS_CRC_HI) ? POS_ADDR : pos_ff + 5'd1;

      cnt_in = cnt_ff;
      if (state_ff == ST_CHECK)            cnt_in = POS_ADDR;
      else if (state_ff == ST_REPLY && slot_free) cnt_in = cnt_ff + 5'd1;

      own_in = own_ff;
      if (state_ff == ST_CHECK && crc_ok && for_me && set_addr && addr_ok) begin
         own_in = data0_ff[OWN_W-1:0];
      end

      bcast_in = csr_wr_en ? csr_wr_data : bcast_ff;

      if (load_out)       rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else                rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         pos_ff       <= POS_ADDR;
         cnt_ff       <= POS_ADDR;
         own_ff       <= 4'd1;
         bcast_ff     <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         own_ff       <= own_in;
         bcast_ff     <= bcast_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // captured header and trailer bytes of the frame
   always_ff @(posedge clock) begin
      if (req_accept) begin
         unique case (pos_ff)
            POS_ADDR:   addr_ff   <= req_rx_byte;
            POS_CMD:    cmd_ff    <= req_rx_byte;
            POS_DATA0:  data0_ff  <= req_rx_byte;
            POS_CRC_LO: crc_lo_ff <= req_rx_byte;
            POS_CRC_HI: crc_hi_ff <= req_rx_byte;
            default: begin
            end
         endcase
      end
      if (load_out) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_kind = rsp_kind_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   `FSFR_ASSERT_NOW(a_notice_last, clock, reset, rsp_valid_ff && rsp_kind_ff, rsp_last_ff)
   `FSFR_ASSERT_NOW(a_notice_range, clock, reset, rsp_valid_ff && rsp_kind_ff,
                    (rsp_byte_ff != ZERO_BYTE) && (rsp_byte_ff <= ADDR_MAX_BYTE))
   `FSFR_ASSERT_NOW(a_own_range, clock, reset, 1'b1,
                    (own_ff != 4'd0) && ({4'h0, own_ff} <= ADDR_MAX_BYTE))
   `FSFR_ASSERT_NEXT(a_frame_end_check, clock, reset,
                     req_accept && (pos_ff == POS_CRC_HI), state_ff == ST_CHECK)
   `FSFR_ASSERT_NOW(a_reply_count, clock, reset, state_ff == ST_REPLY, cnt_ff <= POS_CRC_HI)

endmodule
